>>> src/assert_macros.svh
// Assertion helpers used by the checker file lsrr_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk, quiet while rst is high.
`define LSRR_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lsrr assertion failed");

// Clocked on clk, also checked during reset.
`define LSRR_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("lsrr assertion failed");

`endif

>>> src/lsrr_pkg.sv
package lsrr_pkg;

  localparam int MAX_SERVERS = 8;
  localparam int SRV_IDX_W   = $clog2(MAX_SERVERS);
  localparam int SRV_CNT_W   = 4;
  localparam int NODE_W      = 8;
  localparam int TICKS_W     = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_CLIENT_ID    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERVER_IDS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SERVER_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_TARGET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF      = 3'd5;

  // reset values
  localparam logic [31:0]          CLIENT_ID_RST    = 32'd1;
  localparam logic [63:0]          SERVER_IDS_RST   = 64'd0;
  localparam logic [SRV_CNT_W-1:0] SERVER_COUNT_RST = 4'd1;
  localparam logic [SRV_IDX_W-1:0] START_TARGET_RST = 3'd0;
  localparam logic [TICKS_W-1:0]   TIMEOUT_RST      = 20'd1000;
  localparam logic [TICKS_W-1:0]   BACKOFF_RST      = 20'd100;

  // stats slots
  localparam int STAT_DONE      = 0;
  localparam int STAT_NOTLEADER = 1;
  localparam int STAT_TIMEOUT   = 2;
  localparam int STAT_N         = 3;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_REPLY = 2'd1,
    CMD_TICK  = 2'd2
  } command_e;

  typedef enum logic [1:0] {
    EV_SEND = 2'd0,
    EV_DONE = 2'd1,
    EV_BUSY = 2'd2
  } event_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [1:0]        op;
    logic [15:0]       request_tag;
    logic              well_formed;
    logic [NODE_W-1:0] reply_from;
    logic [31:0]       reply_client;
    logic [31:0]       reply_seq;
    logic              reply_ok;
    logic              hint_valid;
    logic [NODE_W-1:0] hint_node;
    logic [15:0]       result_tag;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]        event_kind;
    logic [NODE_W-1:0] dest_node;
    logic [31:0]       out_seq;
    logic [1:0]        out_op;
    logic [15:0]       out_request_tag;
    logic [15:0]       out_result_tag;
  } evt_item_t;

  typedef struct packed {
    logic [31:0]                 own_client_id;
    logic [MAX_SERVERS*NODE_W-1:0] server_ids;
    logic [SRV_CNT_W-1:0]        server_count;
    logic [TICKS_W-1:0]          timeout_ticks;
    logic [TICKS_W-1:0]          backoff_ticks;
    logic                        target_load;
    logic [SRV_IDX_W-1:0]        target_value;
  } cfg_t;

  typedef struct packed {
    logic      emit;
    evt_item_t item;
  } ctrl_res_t;

  // zero acts as one, above the table size acts as the table size
  function automatic logic [SRV_CNT_W-1:0] count_used(input logic [SRV_CNT_W-1:0] cnt);
    logic [SRV_CNT_W-1:0] r;
    if (cnt == '0) r = SRV_CNT_W'(1);
    else if (cnt > SRV_CNT_W'(MAX_SERVERS)) r = SRV_CNT_W'(MAX_SERVERS);
    else r = cnt;
    return r;
  endfunction

  function automatic logic [NODE_W-1:0] node_at(
    input logic [MAX_SERVERS*NODE_W-1:0] ids,
    input logic [SRV_IDX_W-1:0]          idx
  );
    return ids[idx*NODE_W +: NODE_W];
  endfunction

  // (idx + 1) mod cnt; values are tiny, a few conditional subtracts settle it
  function automatic logic [SRV_IDX_W-1:0] next_index(
    input logic [SRV_IDX_W-1:0] idx,
    input logic [SRV_CNT_W-1:0] cnt
  );
    logic [SRV_CNT_W-1:0] v;
    v = SRV_CNT_W'(idx) + SRV_CNT_W'(1);
    for (int k = 0; k < MAX_SERVERS; k++) begin
      if (v >= cnt) v = v - cnt;
    end
    return v[SRV_IDX_W-1:0];
  endfunction

  function automatic logic [TICKS_W-1:0] load_ticks(input logic [TICKS_W-1:0] t);
    return (t == '0) ? TICKS_W'(1) : t;
  endfunction

endpackage

>>> src/leader_seeking_request_retry_core.sv
// Channel   Direction  Handshake                Payload
// cmd       in         cmd_valid / cmd_stall    cmd_item_t (start, reply or tick)
// evt       out        evt_valid / evt_stall    evt_item_t (send, done or busy)
// cfg       in         cfg_we, cfg_index        cfg_data, 64 bits, write only
//
// One request per cycle unless evt_stall holds a result; results are registered.
// The decision stage (hint compares, timers, counters) is combinational logic.
// Reset is synchronous and clears all control state; no clearing pass.
// cmd_stall rises only while a request waits in the input register and the
// result register is held by evt_stall.
module leader_seeking_request_retry_core
  import lsrr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  cmd_item_t             cmd_data,
  output logic                  evt_valid,
  input  logic                  evt_stall,
  output evt_item_t             evt_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  ctrl_res_t res;

  // input register
  logic      q_valid;
  cmd_item_t q;
  logic      cmd_accept;
  logic      advance;
  logic      evt_held;

  // result register is busy only if it holds an untaken result
  assign evt_held   = evt_valid && evt_stall;
  assign advance    = q_valid && !evt_held;
  assign cmd_stall  = q_valid && evt_held;
  assign cmd_accept = cmd_valid && !cmd_stall;

  lsrr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // state lives here; one decision per advanced request
  lsrr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (q),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (cmd_accept) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) q <= cmd_data;
  end

  // result register: loads on an emitting decision, drains when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (advance && res.emit) begin
      evt_valid <= 1'b1;
    end else if (!evt_stall) begin
      evt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) evt_data <= res.item;
  end

endmodule

>>> src/lsrr_cfg.sv
module lsrr_cfg
  import lsrr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [31:0]                   own_client_id;
  logic [MAX_SERVERS*NODE_W-1:0] server_ids;
  logic [SRV_CNT_W-1:0]          server_count;
  logic [TICKS_W-1:0]            timeout_ticks;
  logic [TICKS_W-1:0]            backoff_ticks;
  logic                          target_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_client_id <= CLIENT_ID_RST;
      server_ids    <= SERVER_IDS_RST;
      server_count  <= SERVER_COUNT_RST;
      timeout_ticks <= TIMEOUT_RST;
      backoff_ticks <= BACKOFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLIENT_ID:    own_client_id <= cfg_data[31:0];
        REG_SERVER_IDS:   server_ids    <= cfg_data[MAX_SERVERS*NODE_W-1:0];
        REG_SERVER_COUNT: server_count  <= cfg_data[SRV_CNT_W-1:0];
        REG_TIMEOUT:      timeout_ticks <= cfg_data[TICKS_W-1:0];
        REG_BACKOFF:      backoff_ticks <= cfg_data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // start_target is only ever seen through the target load it causes
  assign target_load = cfg_we && (cfg_index == REG_START_TARGET);

  assign cfg.own_client_id = own_client_id;
  assign cfg.server_ids    = server_ids;
  assign cfg.server_count  = server_count;
  assign cfg.timeout_ticks = timeout_ticks;
  assign cfg.backoff_ticks = backoff_ticks;
  assign cfg.target_load   = target_load;
  assign cfg.target_value  = cfg_data[SRV_IDX_W-1:0];

endmodule

>>> src/lsrr_hint_match.sv
module lsrr_hint_match
  import lsrr_pkg::*;
(
  input  logic [MAX_SERVERS*NODE_W-1:0] server_ids,
  input  logic [SRV_CNT_W-1:0]          cnt,
  input  logic [NODE_W-1:0]             hint_node,
  output logic                          found,
  output logic [SRV_IDX_W-1:0]          found_idx
);

  // parallel compares; scan from the top so the lowest hit wins
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = MAX_SERVERS - 1; i >= 0; i--) begin
      if ((SRV_CNT_W'(i) < cnt) &&
          (server_ids[i*NODE_W +: NODE_W] == hint_node)) begin
        found     = 1'b1;
        found_idx = SRV_IDX_W'(i);
      end
    end
  end

endmodule

>>> src/lsrr_ctrl.sv
module lsrr_ctrl
  import lsrr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  cmd_item_t item,
  input  cfg_t      cfg,
  output ctrl_res_t res
);

  logic                 pending,       pending_next;
  logic [31:0]          pending_seq,   pending_seq_next;
  logic [1:0]           pending_op,    pending_op_next;
  logic [15:0]          pending_tag,   pending_tag_next;
  logic [31:0]          seq_counter,   seq_counter_next;
  logic [SRV_IDX_W-1:0] target_index,  target_index_next;
  logic [TICKS_W-1:0]   timeout_left,  timeout_left_next;
  logic                 timeout_armed, timeout_armed_next;
  logic [TICKS_W-1:0]   backoff_left,  backoff_left_next;
  logic                 backoff_armed, backoff_armed_next;
  logic [31:0]          stat_counts      [STAT_N];
  logic [31:0]          stat_counts_next [STAT_N];

  logic                 do_send;
  logic [SRV_CNT_W-1:0] cnt;
  logic                 hint_found;
  logic [SRV_IDX_W-1:0] hint_idx;
  logic                 reply_match;
  logic [TICKS_W-1:0]   timeout_dec;
  logic [TICKS_W-1:0]   backoff_dec;

  assign cnt = count_used(cfg.server_count);

  lsrr_hint_match u_hint (
    .server_ids (cfg.server_ids),
    .cnt        (cnt),
    .hint_node  (item.hint_node),
    .found      (hint_found),
    .found_idx  (hint_idx)
  );

  assign reply_match = item.well_formed && pending &&
                       (item.reply_client == cfg.own_client_id) &&
                       (item.reply_seq == pending_seq);
  assign timeout_dec = timeout_left - TICKS_W'(1);
  assign backoff_dec = backoff_left - TICKS_W'(1);

  always_comb begin
    pending_next       = pending;
    pending_seq_next   = pending_seq;
    pending_op_next    = pending_op;
    pending_tag_next   = pending_tag;
    seq_counter_next   = seq_counter;
    target_index_next  = target_index;
    timeout_left_next  = timeout_left;
    timeout_armed_next = timeout_armed;
    backoff_left_next  = backoff_left;
    backoff_armed_next = backoff_armed;
    stat_counts_next   = stat_counts;
    do_send            = 1'b0;
    res                = '0;

    if (step) begin
      case (item.command)
        CMD_START: begin
          if (pending) begin
            res.emit                 = 1'b1;
            res.item.event_kind      = EV_BUSY;
            res.item.out_op          = item.op;
            res.item.out_request_tag = item.request_tag;
          end else begin
            pending_next     = 1'b1;
            pending_seq_next = seq_counter;
            seq_counter_next = seq_counter + 32'd1;
            pending_op_next  = item.op;
            pending_tag_next = item.request_tag;
            do_send          = 1'b1;
          end
        end
        CMD_REPLY: begin
          if (reply_match) begin
            if (item.reply_ok) begin
              pending_next       = 1'b0;
              timeout_armed_next = 1'b0;
              timeout_left_next  = '0;
              backoff_armed_next = 1'b0;
              backoff_left_next  = '0;
              stat_counts_next[STAT_DONE] = stat_counts[STAT_DONE] + 32'd1;
              res.emit                 = 1'b1;
              res.item.event_kind      = EV_DONE;
              res.item.dest_node       = item.reply_from;
              res.item.out_seq         = pending_seq;
              res.item.out_op          = pending_op;
              res.item.out_request_tag = pending_tag;
              res.item.out_result_tag  = item.result_tag;
            end else begin
              stat_counts_next[STAT_NOTLEADER] = stat_counts[STAT_NOTLEADER] + 32'd1;
              if (item.hint_valid && (item.hint_node != item.reply_from) && hint_found) begin
                target_index_next = hint_idx;
                do_send           = 1'b1;
              end else begin
                // no usable hint: next server, then back off
                target_index_next  = next_index(target_index, cnt);
                timeout_armed_next = 1'b0;
                timeout_left_next  = '0;
                backoff_armed_next = 1'b1;
                backoff_left_next  = load_ticks(cfg.backoff_ticks);
              end
            end
          end
        end
        CMD_TICK: begin
          if (pending) begin
            if (timeout_armed) begin
              timeout_left_next = timeout_dec;
              if (timeout_dec == '0) begin
                timeout_armed_next = 1'b0;
                stat_counts_next[STAT_TIMEOUT] = stat_counts[STAT_TIMEOUT] + 32'd1;
                target_index_next = next_index(target_index, cnt);
                do_send           = 1'b1;
              end
            end
            if (!do_send && backoff_armed) begin
              backoff_left_next = backoff_dec;
              if (backoff_dec == '0) begin
                backoff_armed_next = 1'b0;
                do_send            = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase

      if (do_send) begin
        backoff_armed_next = 1'b0;
        backoff_left_next  = '0;
        timeout_armed_next = 1'b1;
        timeout_left_next  = load_ticks(cfg.timeout_ticks);
        res.emit                 = 1'b1;
        res.item.event_kind      = EV_SEND;
        res.item.dest_node       = node_at(cfg.server_ids, target_index_next);
        res.item.out_seq         = pending_seq_next;
        res.item.out_op          = pending_op_next;
        res.item.out_request_tag = pending_tag_next;
        res.item.out_result_tag  = '0;
      end
    end

    // the user must make config writes only while idle; the block does not enforce it
    if (cfg.target_load) target_index_next = cfg.target_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending       <= 1'b0;
      pending_seq   <= '0;
      pending_op    <= '0;
      pending_tag   <= '0;
      seq_counter   <= '0;
      target_index  <= START_TARGET_RST;
      timeout_left  <= '0;
      timeout_armed <= 1'b0;
      backoff_left  <= '0;
      backoff_armed <= 1'b0;
      for (int s = 0; s < STAT_N; s++) stat_counts[s] <= '0;
    end else begin
      pending       <= pending_next;
      pending_seq   <= pending_seq_next;
      pending_op    <= pending_op_next;
      pending_tag   <= pending_tag_next;
      seq_counter   <= seq_counter_next;
      target_index  <= target_index_next;
      timeout_left  <= timeout_left_next;
      timeout_armed <= timeout_armed_next;
      backoff_left  <= backoff_left_next;
      backoff_armed <= backoff_armed_next;
      stat_counts   <= stat_counts_next;
    end
  end

endmodule

>>> src/lsrr_checker.sv
`include "assert_macros.svh"

module lsrr_checker
  import lsrr_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      cmd_stall,
  input logic      evt_valid,
  input logic      evt_stall,
  input evt_item_t evt_data
);

  // held result stays put
  `LSRR_ASSERT(a_evt_hold, evt_valid && evt_stall |=> evt_valid && $stable(evt_data))

  // nothing comes out of reset
  `LSRR_ASSERT_ALWAYS(a_reset_empty, rst |=> !evt_valid)

  // input only backs up behind a waiting result
  `LSRR_ASSERT(a_cmd_free, !evt_valid |-> !cmd_stall)

  // only completions carry a result handle
  `LSRR_ASSERT(a_restag_zero, evt_valid && (evt_data.event_kind == EV_SEND || evt_data.event_kind == EV_BUSY) |-> evt_data.out_result_tag == 16'd0)

endmodule

bind leader_seeking_request_retry_core lsrr_checker u_lsrr_checker (.*);

>>> sim/lsrr_event_checker.sv
module lsrr_event_checker
  import lsrr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  logic                  cmd_stall,
  input  cmd_item_t             cmd_data,
  input  logic                  evt_valid,
  input  logic                  evt_stall,
  input  evt_item_t             evt_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    owed,
  output logic                  busy_now,
  output logic [31:0]           seq_now,
  output logic [NODE_W-1:0]     node_now
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [31:0]          client_ident;
  logic [63:0]          table_ids;
  logic [SRV_CNT_W-1:0] table_count;
  logic [TICKS_W-1:0]   reply_wait;
  logic [TICKS_W-1:0]   retry_wait;

  // outstanding request and its timers
  logic                 busy;
  logic [31:0]          cur_seq;
  logic [31:0]          seq_next;
  logic [1:0]           cur_op;
  logic [15:0]          cur_tag;
  logic [SRV_IDX_W-1:0] target;
  logic [TICKS_W-1:0]   wait_left;
  logic                 wait_on;
  logic [TICKS_W-1:0]   hold_left;
  logic                 hold_on;

  evt_item_t owed_events[$];

  function automatic int unsigned live_count();
    if (table_count == '0) return 1;
    if (table_count > MAX_SERVERS) return MAX_SERVERS;
    return int'(table_count);
  endfunction

  function automatic logic [NODE_W-1:0] node_of(input int unsigned idx);
    return table_ids[(idx % MAX_SERVERS) * NODE_W +: NODE_W];
  endfunction

  function automatic logic [TICKS_W-1:0] nonzero(input logic [TICKS_W-1:0] t);
    return (t == '0) ? TICKS_W'(1) : t;
  endfunction

  function automatic evt_item_t make_evt(input event_e kind, input logic [NODE_W-1:0] dest,
                                         input logic [31:0] seq, input logic [1:0] op,
                                         input logic [15:0] rtag, input logic [15:0] restag);
    evt_item_t e;
    e.event_kind      = kind;
    e.dest_node       = dest;
    e.out_seq         = seq;
    e.out_op          = op;
    e.out_request_tag = rtag;
    e.out_result_tag  = restag;
    return e;
  endfunction

  // (re)send the request to the current target, reply timer restarts
  task automatic issue_request();
    hold_on   = 1'b0;
    hold_left = '0;
    wait_on   = 1'b1;
    wait_left = nonzero(reply_wait);
    owed_events.push_back(make_evt(EV_SEND, node_of(target), cur_seq, cur_op, cur_tag, 16'h0));
  endtask

  task automatic step_target();
    target = SRV_IDX_W'((target + 1) % live_count());
  endtask

  task automatic clear_state();
    client_ident = CLIENT_ID_RST;
    table_ids    = SERVER_IDS_RST;
    table_count  = SERVER_COUNT_RST;
    reply_wait   = TIMEOUT_RST;
    retry_wait   = BACKOFF_RST;
    target       = START_TARGET_RST;
    busy         = 1'b0;
    cur_seq      = '0;
    seq_next     = '0;
    cur_op       = '0;
    cur_tag      = '0;
    wait_on      = 1'b0;
    wait_left    = '0;
    hold_on      = 1'b0;
    hold_left    = '0;
    owed_events.delete();
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_CLIENT_ID:    client_ident = d[31:0];
      REG_SERVER_IDS:   table_ids = d;
      REG_SERVER_COUNT: table_count = d[SRV_CNT_W-1:0];
      REG_START_TARGET: target = d[SRV_IDX_W-1:0];
      REG_TIMEOUT:      reply_wait = d[TICKS_W-1:0];
      REG_BACKOFF:      retry_wait = d[TICKS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic advance_client(input cmd_item_t c);
    logic redirected;
    logic fired;
    redirected = 1'b0;
    fired      = 1'b0;
    case (c.command)
      CMD_START: begin
        if (busy) begin
          owed_events.push_back(make_evt(EV_BUSY, '0, '0, c.op, c.request_tag, 16'h0));
        end else begin
          busy     = 1'b1;
          cur_seq  = seq_next;
          seq_next = seq_next + 32'd1;
          cur_op   = c.op;
          cur_tag  = c.request_tag;
          issue_request();
        end
      end
      CMD_REPLY: begin
        if (c.well_formed && busy && c.reply_client == client_ident && c.reply_seq == cur_seq)
        begin
          if (c.reply_ok) begin
            busy      = 1'b0;
            wait_on   = 1'b0;
            wait_left = '0;
            hold_on   = 1'b0;
            hold_left = '0;
            owed_events.push_back(make_evt(EV_DONE, c.reply_from, cur_seq, cur_op, cur_tag,
                                           c.result_tag));
          end else begin
            // a hint naming the sender itself counts as no hint; lowest match wins
            if (c.hint_valid && c.hint_node != c.reply_from) begin
              for (int i = 0; i < live_count(); i++) begin
                if (!redirected && node_of(i) == c.hint_node) begin
                  target     = SRV_IDX_W'(i);
                  redirected = 1'b1;
                end
              end
            end
            if (redirected) begin
              issue_request();
            end else begin
              step_target();
              wait_on   = 1'b0;
              wait_left = '0;
              hold_on   = 1'b1;
              hold_left = nonzero(retry_wait);
            end
          end
        end
      end
      CMD_TICK: begin
        if (busy) begin
          if (wait_on) begin
            wait_left = wait_left - TICKS_W'(1);
            if (wait_left == '0) begin
              wait_on = 1'b0;
              step_target();
              issue_request();
              fired = 1'b1;
            end
          end
          if (!fired && hold_on) begin
            hold_left = hold_left - TICKS_W'(1);
            if (hold_left == '0) begin
              hold_on = 1'b0;
              issue_request();
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    evt_item_t want;
    if (rst) begin
      clear_state();
    end else begin
      if (cfg_we) apply_reg(cfg_index, cfg_data);
      if (cmd_valid && !cmd_stall) advance_client(cmd_data);
      if (evt_valid && !evt_stall) begin
        if (owed_events.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected event: kind %0d dest %h seq %h op %0d rtag %h restag %h",
                     evt_data.event_kind, evt_data.dest_node, evt_data.out_seq,
                     evt_data.out_op, evt_data.out_request_tag, evt_data.out_result_tag);
        end else begin
          want = owed_events.pop_front();
          if (want.event_kind !== evt_data.event_kind || want.dest_node !== evt_data.dest_node ||
              want.out_seq !== evt_data.out_seq || want.out_op !== evt_data.out_op ||
              want.out_request_tag !== evt_data.out_request_tag ||
              want.out_result_tag !== evt_data.out_result_tag) begin
            errors++;
            if (errors <= 10)
              $display({"event mismatch: expected kind %0d dest %h seq %h op %0d rtag %h ",
                        "restag %h, got kind %0d dest %h seq %h op %0d rtag %h restag %h"},
                       want.event_kind, want.dest_node, want.out_seq, want.out_op,
                       want.out_request_tag, want.out_result_tag,
                       evt_data.event_kind, evt_data.dest_node, evt_data.out_seq,
                       evt_data.out_op, evt_data.out_request_tag, evt_data.out_result_tag);
          end
        end
      end
    end
    owed     = owed_events.size();
    busy_now = busy;
    seq_now  = cur_seq;
    node_now = node_of(target);
  end

endmodule

>>> sim/tb_leader_seeking_request_retry_core.sv
module tb_leader_seeking_request_retry_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lsrr_pkg::*;

  // run bounds
  localparam int CLOCK_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, fills the pipe
  localparam int PHASE_ITEMS  = 250;   // random commands per register setting
  localparam int SETTINGS_N   = 5;

  // request kinds carried by the block
  localparam logic [1:0] OP_GET    = 2'd0;
  localparam logic [1:0] OP_PUT    = 2'd1;
  localparam logic [1:0] OP_APPEND = 2'd2;
  localparam logic [1:0] OP_ODD    = 2'd3;   // not defined, must pass through
  // command code with no meaning, block must drop it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_stall;
  cmd_item_t             cmd_data = '0;
  logic                  evt_valid;
  logic                  evt_stall = 1'b0;
  evt_item_t             evt_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // from the checker
  int                    errors;
  int                    owed;
  logic                  busy_now;
  logic [31:0]           seq_now;
  logic [NODE_W-1:0]     node_now;

  // stimulus view of what was programmed
  logic [31:0]           my_client = CLIENT_ID_RST;
  logic [63:0]           my_ids = SERVER_IDS_RST;
  logic [SRV_CNT_W-1:0]  my_count = SERVER_COUNT_RST;

  int                    sent_items = 0;
  bit                    tx_calm = 1'b0;   // sender never idles while set
  bit                    rx_calm = 1'b0;   // receiver starts no random stalls while set
  int                    hold_asked = 0;
  int                    hold_done = 0;
  int                    stall_left = 0;
  int                    cycles = 0;

  always #5 clk = ~clk;

  leader_seeking_request_retry_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt_data  (evt_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lsrr_event_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt_data  (evt_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .owed      (owed),
    .busy_now  (busy_now),
    .seq_now   (seq_now),
    .node_now  (node_now)
  );

  // watchdog: a hang anywhere ends the run as a failure
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CLOCK_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // mostly back-to-back, some short gaps, rare long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // event-side backpressure; one decision per falling edge.
  // A hold-off request from the stimulus wins over the random stalls.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (hold_done != hold_asked) begin
      stall_left = HOLD_CYCLES;
      hold_done++;
    end else if (!rx_calm && $urandom_range(0, 2) == 0) begin
      stall_left = pick_gap();
    end
    evt_stall <= (stall_left > 0);
  end

  // Offer one request and return on the falling edge after it is taken.
  // Valid stays high between back-to-back requests; it only drops for a gap.
  task automatic push_cmd(input cmd_item_t c);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_data  <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    @(negedge clk);
    sent_items++;
  endtask

  // drain: everything owed has come out and the last request has settled
  task automatic wait_quiet();
    cmd_valid <= 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
  endtask

  // full register set, written only once the block is idle
  task automatic program_all(input logic [31:0] client, input logic [63:0] ids,
                             input logic [SRV_CNT_W-1:0] count,
                             input logic [SRV_IDX_W-1:0] first,
                             input logic [TICKS_W-1:0] tmo, input logic [TICKS_W-1:0] bko);
    wait_quiet();
    write_reg(REG_CLIENT_ID, CFG_DATA_W'(client));
    write_reg(REG_SERVER_IDS, ids);
    write_reg(REG_SERVER_COUNT, CFG_DATA_W'(count));
    write_reg(REG_START_TARGET, CFG_DATA_W'(first));
    write_reg(REG_TIMEOUT, CFG_DATA_W'(tmo));
    write_reg(REG_BACKOFF, CFG_DATA_W'(bko));
    cfg_we    <= 1'b0;
    my_client = client;
    my_ids    = ids;
    my_count  = count;
  endtask

  function automatic int live_servers();
    if (my_count == '0) return 1;
    if (my_count > MAX_SERVERS) return MAX_SERVERS;
    return int'(my_count);
  endfunction

  function automatic logic [NODE_W-1:0] some_server();
    return my_ids[$urandom_range(0, live_servers() - 1) * NODE_W +: NODE_W];
  endfunction

  // server table with repeats now and then
  function automatic logic [63:0] rand_ids();
    logic [63:0] v;
    logic [7:0]  b;
    v = '0;
    b = '0;
    for (int i = 0; i < MAX_SERVERS; i++) begin
      if (i == 0 || $urandom_range(0, 2) != 0) b = NODE_W'($urandom);
      v[i*NODE_W +: NODE_W] = b;
    end
    return v;
  endfunction

  // every field random; the builders below override what matters
  function automatic cmd_item_t any_item();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return r[$bits(cmd_item_t)-1:0];
  endfunction

  function automatic cmd_item_t start_item(input logic [1:0] op, input logic [15:0] tag);
    cmd_item_t c;
    c = any_item();
    c.command     = CMD_START;
    c.op          = op;
    c.request_tag = tag;
    return c;
  endfunction

  function automatic cmd_item_t tick_item();
    cmd_item_t c;
    c = any_item();
    c.command = CMD_TICK;
    return c;
  endfunction

  // reply that matches the outstanding request
  function automatic cmd_item_t reply_to(input logic [NODE_W-1:0] from, input logic ok,
                                         input logic hv, input logic [NODE_W-1:0] hint);
    cmd_item_t c;
    c = any_item();
    c.command      = CMD_REPLY;
    c.well_formed  = 1'b1;
    c.reply_client = my_client;
    c.reply_seq    = seq_now;
    c.reply_from   = from;
    c.reply_ok     = ok;
    c.hint_valid   = hv;
    c.hint_node    = hint;
    return c;
  endfunction

  // matching reply with random sender and hint; a hint may name a table entry, the sender or neither
  function automatic cmd_item_t rand_reply(input logic ok);
    logic [NODE_W-1:0] from;
    logic [NODE_W-1:0] hint;
    int r;
    r = $urandom_range(0, 9);
    from = (r < 5) ? node_now : (r < 8) ? some_server() : NODE_W'($urandom);
    case ($urandom_range(0, 3))
      0, 1:    hint = some_server();
      2:       hint = from;
      default: hint = NODE_W'($urandom);
    endcase
    return reply_to(from, ok, $urandom_range(0, 4) != 0, hint);
  endfunction

  // a reply the block must drop: malformed, foreign client or stale sequence
  function automatic cmd_item_t broken_reply();
    cmd_item_t c;
    c = rand_reply(1'($urandom_range(0, 1)));
    case ($urandom_range(0, 3))
      0:       c.well_formed = 1'b0;
      1:       c.reply_client = c.reply_client ^ (32'd1 << $urandom_range(0, 31));
      2:       c.reply_seq = c.reply_seq ^ (32'd1 << $urandom_range(0, 31));
      default: c.reply_client = $urandom;
    endcase
    return c;
  endfunction

  // one request from start to completion with random trouble on the way
  task automatic run_request();
    int steps;
    int k;
    push_cmd(start_item(2'($urandom_range(0, 3)), 16'($urandom)));
    steps = $urandom_range(0, 8);
    repeat (steps) begin
      k = $urandom_range(0, 99);
      if (k < 30) repeat ($urandom_range(1, 4)) push_cmd(tick_item());
      else if (k < 55) push_cmd(rand_reply(1'b0));
      else if (k < 70) push_cmd(broken_reply());
      else if (k < 80) push_cmd(start_item(2'($urandom_range(0, 3)), 16'($urandom)));
      else if (k < 88) push_cmd(any_item());
      else push_cmd(rand_reply(1'b1));
    end
    if (busy_now) push_cmd(rand_reply(1'b1));
  endtask

  initial begin
    cmd_item_t c;
    int goal;

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed ---
    // reset settings: one server, node 0, client 1
    push_cmd(start_item(OP_GET, 16'h0000));
    push_cmd(reply_to(8'h00, 1'b1, 1'b0, 8'h00));

    // nodes by index: 10 20 30 20(repeat) 50 60 70 80; four in use, start at index 1
    program_all(32'h0000_0005, 64'h8070_6050_2030_2010, 4'd4, 3'd1, 20'd3, 20'd2);
    push_cmd(start_item(OP_ODD, 16'hFFFF));          // sent to 20
    push_cmd(start_item(OP_APPEND, 16'h1234));       // busy
    c = reply_to(8'h20, 1'b1, 1'b0, 8'h00);
    c.well_formed = 1'b0;
    push_cmd(c);                                     // malformed, dropped
    c = reply_to(8'h20, 1'b1, 1'b0, 8'h00);
    c.reply_client = ~my_client;
    push_cmd(c);                                     // other client, dropped
    c = reply_to(8'h20, 1'b1, 1'b0, 8'h00);
    c.reply_seq = seq_now + 32'd1;
    push_cmd(c);                                     // stale sequence, dropped
    push_cmd(reply_to(8'h20, 1'b0, 1'b1, 8'h30));    // redirect to index 2
    push_cmd(reply_to(8'h30, 1'b0, 1'b1, 8'h30));    // hint is the sender: backoff, index 3
    repeat (2) push_cmd(tick_item());                // backoff runs out, resend
    push_cmd(reply_to(8'h20, 1'b0, 1'b1, 8'h77));    // hint not in table: backoff, index 0
    repeat (2) push_cmd(tick_item());
    repeat (3) push_cmd(tick_item());                // reply timeout, index 1
    push_cmd(reply_to(8'h10, 1'b0, 1'b1, 8'h20));    // hint twice in table, lowest index
    repeat (3) push_cmd(tick_item());                // timeout goes on to index 2
    push_cmd(reply_to(8'hFF, 1'b1, 1'b0, 8'h00));    // done, sender taken from reply
    push_cmd(tick_item());                           // tick with nothing outstanding
    push_cmd(reply_to(8'h10, 1'b1, 1'b0, 8'h00));    // reply with nothing outstanding
    c = '1;
    c.command = CMD_UNUSED;
    push_cmd(c);
    push_cmd(start_item(OP_PUT, 16'h8001));
    push_cmd(reply_to(node_now, 1'b1, 1'b0, 8'h00));

    // --- pressure: hold the event side while starts keep coming ---
    tx_calm = 1'b1;
    hold_asked++;
    push_cmd(start_item(OP_GET, 16'($urandom)));
    repeat (30) push_cmd(start_item(2'($urandom_range(0, 3)), 16'($urandom)));
    push_cmd(reply_to(node_now, 1'b1, 1'b0, 8'h00));
    tx_calm = 1'b0;

    // --- random, several register settings including the extremes ---
    for (int p = 0; p < SETTINGS_N; p++) begin
      case (p)
        // timers fire on every tick, full table
        0: program_all($urandom | 32'd1, rand_ids(), 4'd8, SRV_IDX_W'($urandom_range(0, 7)),
                       20'd1, 20'd1);
        // zero count and zero timers act as one; start index past the count
        1: program_all(32'hFFFF_FFFF, rand_ids(), 4'd0, 3'd7, 20'd0, 20'd0);
        // count above the table size
        2: program_all(32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 3'd5, 20'd4, 20'd3);
        3: program_all($urandom, rand_ids(), SRV_CNT_W'($urandom_range(1, 8)),
                       SRV_IDX_W'($urandom_range(0, 7)),
                       TICKS_W'($urandom_range(2, 6)), TICKS_W'($urandom_range(1, 5)));
        // timers that never run out within a request
        default: program_all(32'h0000_0001, 64'h0, 4'd3, 3'd2, 20'hFFFFF, 20'hFFFFF);
      endcase
      goal = sent_items + PHASE_ITEMS;
      while (sent_items < goal) begin
        tx_calm = ($urandom_range(0, 5) == 0);
        rx_calm = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 9) == 0) push_cmd(any_item());
        else run_request();
      end
    end

    wait_quiet();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
